// ===== design/vlce_pkg.sv =====
// ============================================================================
// Vector line command encoder package
// Shared widths, register codes, word constants and the types that travel
// between the front end, the queue and the back end.
// ============================================================================
package vlce_pkg;

   // Field widths
   localparam int FRAC_W    = 16;   // Q0.16 coordinate fraction
   localparam int INTEN_W   = 8;    // beam intensity
   localparam int SCALE_W   = 16;   // signed Q8.8 scale
   localparam int OFF_W     = 14;   // signed offset
   localparam int ROT_W     = 2;
   localparam int WORD_W    = 32;
   localparam int PIX_W     = 12;   // packed screen coordinate
   localparam int BRIGHT_W  = 6;

   // Mapping arithmetic: diff = frac*COORD_MAX - (COORD_MAX/2)<<16 fits 28 bits
   // signed for any COORD_MAX up to 4095; the product with the scale then
   // needs 44 bits, and the offset term one more bit.
   localparam int DIFF_W    = 28;
   localparam int PROD_W    = DIFF_W + SCALE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int DIV_SHIFT = FRAC_W + 8;  // Q0.16 times Q8.8
   localparam int CRD_W     = 20;          // mapped coordinate, full precision
   localparam int LANES     = 4;           // start x, start y, end x, end y

   // Input and output channel layout
   localparam int REQ_DATA_W = 4 * FRAC_W + INTEN_W;  // 72 bits, whole bytes
   localparam int RSP_DATA_W = WORD_W;

   // Queue between front end and back end
   localparam int QDEPTH  = 8;
   localparam int QADDR_W = 3;
   localparam int QLVL_W  = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_ROTATE_MODE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BRIGHT_THR  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SCALE_X     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SCALE_Y     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_X    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;

   // Rotation codes
   localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
   localparam logic [ROT_W-1:0] ROT_P90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_P180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_M90   = 2'd3;

   // Output word constants
   localparam logic [1:0]          WORD_TAG    = 2'b10;
   localparam logic [WORD_W-1:0]   WORD_DONE   = 32'h0101_0101;
   localparam logic [WORD_W-1:0]   WORD_ZERO   = 32'h0000_0000;
   localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 6'd3;

   typedef struct packed {
      logic [ROT_W-1:0]          rotate_mode;
      logic [INTEN_W-1:0]        bright_threshold;
      logic signed [SCALE_W-1:0] scale_x;
      logic signed [SCALE_W-1:0] scale_y;
      logic signed [OFF_W-1:0]   offset_x;
      logic signed [OFF_W-1:0]   offset_y;
   } cfg_type;

   // One classified item waiting for the back end
   typedef struct packed {
      logic                      eof;
      logic                      transit;
      logic signed [CRD_W-1:0]   x0;
      logic signed [CRD_W-1:0]   y0;
      logic signed [CRD_W-1:0]   x1;
      logic signed [CRD_W-1:0]   y1;
      logic [INTEN_W-1:0]        intensity;
   } entry_type;

endpackage

// ===== design/vlce_queue.sv =====
// ============================================================================
// Vector line command encoder queue
// Small first-in first-out buffer of classified items between front and back.
// ============================================================================
module vlce_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  vlce_pkg::entry_type         push_entry,
   input  logic                        pop,
   output logic                        head_valid,
   output vlce_pkg::entry_type         head_entry,
   output logic [vlce_pkg::QLVL_W-1:0] level
);
   import vlce_pkg::*;

   entry_type          mem_ff [QDEPTH];
   logic [QADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]  level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QADDR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QADDR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== design/vlce_front.sv =====
// ============================================================================
// Vector line command encoder front end
// Accepts items, maps the four endpoint coordinates in a four-stage pipeline
// and classifies each segment as continuous or needing a blank transit word.
// ============================================================================
module vlce_front #(
   parameter int COORD_MAX = 4095
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vlce_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  vlce_pkg::cfg_type               cfg,
   input  logic [vlce_pkg::QLVL_W-1:0]     q_level,
   output logic                            q_push,
   output vlce_pkg::entry_type             q_entry
);
   import vlce_pkg::*;

   localparam int STAGES = 4;
   localparam logic signed [DIFF_W-1:0] MUL_K = DIFF_W'(COORD_MAX);
   localparam logic signed [DIFF_W-1:0] MID_K = DIFF_W'((COORD_MAX / 2) * (2 ** FRAC_W));
   localparam logic signed [SUM_W-1:0]  TRUNC_BIAS = SUM_W'((2 ** DIV_SHIFT) - 1);

   logic                       accept;
   logic [STAGES-1:0]          vld_ff, vld_in;
   logic                       eof_ff   [STAGES];
   logic [INTEN_W-1:0]         inten_ff [STAGES];

   logic signed [DIFF_W-1:0]   diff_ff [LANES], diff_in [LANES];
   logic signed [PROD_W-1:0]   prod_ff [LANES], prod_in [LANES];
   logic signed [SUM_W-1:0]    sum_ff  [LANES], sum_in  [LANES];
   logic signed [SUM_W-1:0]    biased  [LANES];
   logic signed [CRD_W-1:0]    crd_ff  [LANES], crd_in  [LANES];

   logic signed [CRD_W-1:0]    prev_x_ff, prev_x_in;
   logic signed [CRD_W-1:0]    prev_y_ff, prev_y_in;
   logic [QLVL_W:0]            occupancy;

   // Room is reserved for every item still in the pipeline, so the pipeline
   // itself never has to stall.
   always_comb begin
      occupancy = (QLVL_W+1)'(q_level)
                + (QLVL_W+1)'(vld_ff[0]) + (QLVL_W+1)'(vld_ff[1])
                + (QLVL_W+1)'(vld_ff[2]) + (QLVL_W+1)'(vld_ff[3]);
   end

   assign req_tready = !reset && (occupancy < (QLVL_W+1)'(QDEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      vld_in = {vld_ff[STAGES-2:0], accept};
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         diff_in[l] = $signed({{(DIFF_W-FRAC_W){1'b0}}, req_tdata[l*FRAC_W +: FRAC_W]})
                    * MUL_K - MID_K;
         prod_in[l] = (((l % 2) != 0) ? PROD_W'(cfg.scale_y) : PROD_W'(cfg.scale_x))
                    * PROD_W'(diff_ff[l]);
         sum_in[l]  = SUM_W'(prod_ff[l])
                    + ((((l % 2) != 0) ? SUM_W'(cfg.offset_y) : SUM_W'(cfg.offset_x))
                       <<< DIV_SHIFT);
         // Truncation toward zero: bias negative sums before the shift.
         biased[l]  = sum_ff[l] + (sum_ff[l][SUM_W-1] ? TRUNC_BIAS : SUM_W'(0));
         crd_in[l]  = biased[l][DIV_SHIFT +: CRD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      eof_ff[0]   <= req_tuser;
      inten_ff[0] <= req_tdata[4*FRAC_W +: INTEN_W];
      for (int s = 1; s < STAGES; s++) begin
         eof_ff[s]   <= eof_ff[s-1];
         inten_ff[s] <= inten_ff[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
         diff_ff[l] <= diff_in[l];
         prod_ff[l] <= prod_in[l];
         sum_ff[l]  <= sum_in[l];
         crd_ff[l]  <= crd_in[l];
      end
   end

   // The last end point advances in item order as segments leave the pipeline.
   always_comb begin
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (vld_ff[STAGES-1] && !eof_ff[STAGES-1]) begin
         prev_x_in = crd_ff[2];
         prev_y_in = crd_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   always_comb begin
      q_push            = vld_ff[STAGES-1];
      q_entry.eof       = eof_ff[STAGES-1];
      q_entry.transit   = (crd_ff[0] != prev_x_ff) || (crd_ff[1] != prev_y_ff);
      q_entry.x0        = crd_ff[0];
      q_entry.y0        = crd_ff[1];
      q_entry.x1        = crd_ff[2];
      q_entry.y1        = crd_ff[3];
      q_entry.intensity = inten_ff[STAGES-1];
   end

endmodule

// ===== design/vlce_back.sv =====
// ============================================================================
// Vector line command encoder back end
// Walks the words of each queued item, packs display words and holds them in
// the output register until the downstream side takes them.
// ============================================================================
module vlce_back #(
   parameter int COORD_MAX = 4095
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vlce_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  vlce_pkg::entry_type             q_entry,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vlce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import vlce_pkg::*;

   localparam logic [PIX_W-1:0]        PIX_MAX = PIX_W'(COORD_MAX);
   localparam logic signed [CRD_W-1:0] CRD_MAX = CRD_W'(COORD_MAX);

   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        last_phase;
   logic              final_word;
   logic              load;
   logic              tvalid_ff, tvalid_in;
   logic [WORD_W-1:0] tdata_ff, tdata_in;
   logic              tlast_ff, tlast_in;

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [CRD_W-1:0] v);
      logic [PIX_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > CRD_MAX) begin
         r = PIX_MAX;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] pack_point(
      input logic signed [CRD_W-1:0] xi,
      input logic signed [CRD_W-1:0] yi,
      input logic [INTEN_W-1:0]      inten,
      input cfg_type                 c
   );
      logic [PIX_W-1:0]    xc;
      logic [PIX_W-1:0]    yf;
      logic [PIX_W-1:0]    xr;
      logic [PIX_W-1:0]    yr;
      logic [BRIGHT_W-1:0] bright;
      xc = clamp_pix(xi);
      yf = PIX_MAX - clamp_pix(yi);
      if (inten > c.bright_threshold) begin
         bright = BRIGHT_FULL;
      end else begin
         bright = inten[INTEN_W-1:2];  // zero intensity gives zero as well
      end
      unique case (c.rotate_mode)
         ROT_P90: begin
            xr = PIX_MAX - yf;
            yr = xc;
         end
         ROT_P180: begin
            xr = PIX_MAX - xc;
            yr = PIX_MAX - yf;
         end
         ROT_M90: begin
            xr = yf;
            yr = PIX_MAX - xc;
         end
         default: begin
            xr = xc;
            yr = yf;
         end
      endcase
      return {WORD_TAG, bright, xr, yr};
   endfunction

   always_comb begin
      if (q_entry.eof) begin
         last_phase = 2'd2;
      end else if (q_entry.transit) begin
         last_phase = 2'd1;
      end else begin
         last_phase = 2'd0;
      end
      final_word = (phase_ff == last_phase);
      load       = q_valid && (!tvalid_ff || rsp_tready);
      q_pop      = load && final_word;

      phase_in = phase_ff;
      if (load) begin
         phase_in = final_word ? 2'd0 : phase_ff + 2'd1;
      end

      tvalid_in = tvalid_ff && !rsp_tready;
      tdata_in  = tdata_ff;
      tlast_in  = tlast_ff;
      if (load) begin
         tvalid_in = 1'b1;
         tlast_in  = final_word;
         if (q_entry.eof) begin
            tdata_in = (phase_ff == 2'd0) ? WORD_DONE : WORD_ZERO;
         end else if (q_entry.transit && (phase_ff == 2'd0)) begin
            tdata_in = pack_point(q_entry.x0, q_entry.y0, '0, cfg);
         end else begin
            tdata_in = pack_point(q_entry.x1, q_entry.y1, q_entry.intensity, cfg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         tvalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tvalid_ff <= tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      tdata_ff <= tdata_in;
      tlast_ff <= tlast_in;
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tlast  = tlast_ff;

endmodule

// ===== design/vector_line_command_encoder_unit.sv =====
// ============================================================================
// Vector line command encoder
// Converts line segments and end-of-frame markers into 32-bit vector display
// command words, with an APB-style register port for scale, offset and mode.
// ============================================================================
// A segment's first word passes the four mapping stages, the queue write and
// then the output register. The front end takes one item per cycle while the
// queue has room; the output register delivers one word per cycle while the
// downstream side takes it, so a continuous segment gives one word, a segment
// with a transit word two, and an end of frame three. Reset is synchronous;
// it empties the pipeline and the queue, sets the registers to their defaults
// and clears the stored end point.
module vector_line_command_encoder_unit #(
   parameter int COORD_MAX = 4095
) (
   input  logic                            clock,
   input  logic                            reset,

   // Input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48],
   // intensity [71:64]
   input  logic [vlce_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd [0]: 0 draw segment, 1 end of frame
   input  logic                            req_tuser,

   // Result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // word [31:0]
   output logic [vlce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // last: set on the final word caused by an input item
   output logic                            rsp_tlast,

   // Register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vlce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vlce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vlce_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import vlce_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   logic               q_push;
   entry_type          q_push_entry;
   logic               q_pop;
   logic               q_valid;
   entry_type          q_head;
   logic [QLVL_W-1:0]  q_level;

   // ------------------------------------------------------------------------
   // Register file. Registers sit at byte address 4*index; writes to unused
   // addresses are dropped and read back as zero. The port never waits.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROTATE_MODE: cfg_in.rotate_mode      = csr_pwdata[ROT_W-1:0];
            REG_BRIGHT_THR:  cfg_in.bright_threshold = csr_pwdata[INTEN_W-1:0];
            REG_SCALE_X:     cfg_in.scale_x          = csr_pwdata[SCALE_W-1:0];
            REG_SCALE_Y:     cfg_in.scale_y          = csr_pwdata[SCALE_W-1:0];
            REG_OFFSET_X:    cfg_in.offset_x         = csr_pwdata[OFF_W-1:0];
            REG_OFFSET_Y:    cfg_in.offset_y         = csr_pwdata[OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotate_mode      <= ROT_NONE;
         cfg_ff.bright_threshold <= '1;
         cfg_ff.scale_x          <= SCALE_W'(256);  // 1.0 in Q8.8
         cfg_ff.scale_y          <= SCALE_W'(256);
         cfg_ff.offset_x         <= '0;
         cfg_ff.offset_y         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROTATE_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.rotate_mode);
         REG_BRIGHT_THR:  csr_prdata = CSR_DATA_W'(cfg_ff.bright_threshold);
         REG_SCALE_X:     csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.scale_x));
         REG_SCALE_Y:     csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.scale_y));
         REG_OFFSET_X:    csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.offset_x));
         REG_OFFSET_Y:    csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.offset_y));
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Front end: maps the four endpoint coordinates, tracks the last end point
   // and decides whether a blank transit word must precede the drawn word.
   // It only takes an item when the queue can hold everything in flight.
   // ------------------------------------------------------------------------
   vlce_front #(
      .COORD_MAX (COORD_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_level    (q_level),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   // Queue of classified items; lets the front keep accepting while the
   // output side is stalled or busy with multi-word items.
   vlce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head),
      .level      (q_level)
   );

   // Back end: clamps, flips and rotates points, sets brightness and emits
   // one word per cycle into the output register while the downstream side takes them.
   vlce_back #(
      .COORD_MAX (COORD_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/vlce_checker.sv =====
// ============================================================================
// Vector line command encoder checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
module vlce_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vlce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import vlce_pkg::*;

   // A word that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Every word is a display word or one of the end-of-frame words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[WORD_W-1:WORD_W-2] != WORD_TAG)
      |-> (rsp_tdata == WORD_DONE) || (rsp_tdata == WORD_ZERO))
      else $error("malformed result word");

   // The done word opens an end-of-frame sequence and never closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == WORD_DONE) |-> !rsp_tlast)
      else $error("done word marked as last");

endmodule

bind vector_line_command_encoder_unit vlce_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
